[rtl/slot_allocator_reuse_delay_macros.svh]
// Assertion macros shared by the slot allocator RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef SLOT_ALLOCATOR_REUSE_DELAY_MACROS_SVH
`define SLOT_ALLOCATOR_REUSE_DELAY_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SRA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// invariant on every cycle out of reset
`define SRA_ASSERT_ALWAYS(lbl, clk, rst_n, cons, msg) \
    `SRA_ASSERT_IMPL(lbl, clk, rst_n, 1'b1, cons, msg)

`endif

[rtl/sra_pkg.sv]
// Shared types and constants for the slot allocator.
// No dependencies.
`timescale 1ns / 1ps

package sra_pkg;

    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned SLOT_W     = 10;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned NOW_W      = 32;
    localparam int unsigned LIMIT_W    = 11;
    localparam int unsigned MS_W       = 16;

    localparam logic [SLOT_W-1:0]  RST_FIRST_SLOT    = 10'd2;
    localparam logic [SLOT_W-1:0]  RST_PROTECT_LIMIT = 10'd1;
    localparam logic [LIMIT_W-1:0] RST_SLOT_LIMIT    = 11'd1024;
    localparam logic [MS_W-1:0]    RST_QUARANTINE_MS = 16'd500;
    localparam logic [MS_W-1:0]    RST_GRACE_MS      = 16'd2000;

    typedef enum logic [2:0] {
        REG_FIRST_SLOT    = 3'd0,
        REG_PROTECT_LIMIT = 3'd1,
        REG_SLOT_LIMIT    = 3'd2,
        REG_QUARANTINE_MS = 3'd3,
        REG_GRACE_MS      = 3'd4
    } t_reg_idx;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED   = 2'd0,
        ST_NONE      = 2'd1,
        ST_FREED     = 2'd2,
        ST_PROTECTED = 2'd3
    } t_status;

    typedef struct packed {
        logic [SLOT_W-1:0]  first_slot;
        logic [SLOT_W-1:0]  protect_limit;
        logic [LIMIT_W-1:0] slot_limit;
        logic [MS_W-1:0]    quarantine_ms;
        logic [MS_W-1:0]    grace_ms;
    } t_cfg;

endpackage

[rtl/sra_if.sv]
// Request and response channel interfaces for the slot allocator.
// Depends on sra_pkg for field widths.
`timescale 1ns / 1ps

interface sra_req_if;
    import sra_pkg::*;
    logic              valid;
    logic              ready;
    logic              op;
    logic [SLOT_W-1:0] slot_index;
    logic [NOW_W-1:0]  now_ms;

    modport source(output valid, output op, output slot_index, output now_ms, input ready);
    modport sink(input valid, input op, input slot_index, input now_ms, output ready);
endinterface

interface sra_rsp_if;
    import sra_pkg::*;
    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   granted_slot;
    logic [STATUS_W-1:0] status;

    modport source(output valid, output granted_slot, output status, input ready);
    modport sink(input valid, input granted_slot, input status, output ready);
endinterface

[rtl/sra_regs.sv]
// APB configuration register file for the slot allocator.
// Depends on sra_pkg.
`timescale 1ns / 1ps

module sra_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sra_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [sra_pkg::DATA_W-1:0]       pwdata,
    output logic [sra_pkg::DATA_W-1:0]       prdata,
    output logic                             pready,
    output sra_pkg::t_cfg                    o_cfg
);
    import sra_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_FIRST_SLOT:    n_cfg.first_slot    = pwdata[SLOT_W-1:0];
                REG_PROTECT_LIMIT: n_cfg.protect_limit = pwdata[SLOT_W-1:0];
                REG_SLOT_LIMIT:    n_cfg.slot_limit    = pwdata[LIMIT_W-1:0];
                REG_QUARANTINE_MS: n_cfg.quarantine_ms = pwdata[MS_W-1:0];
                REG_GRACE_MS:      n_cfg.grace_ms      = pwdata[MS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_FIRST_SLOT:    prdata = DATA_W'(r_cfg.first_slot);
            REG_PROTECT_LIMIT: prdata = DATA_W'(r_cfg.protect_limit);
            REG_SLOT_LIMIT:    prdata = DATA_W'(r_cfg.slot_limit);
            REG_QUARANTINE_MS: prdata = DATA_W'(r_cfg.quarantine_ms);
            REG_GRACE_MS:      prdata = DATA_W'(r_cfg.grace_ms);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{first_slot:    RST_FIRST_SLOT,
                       protect_limit: RST_PROTECT_LIMIT,
                       slot_limit:    RST_SLOT_LIMIT,
                       quarantine_ms: RST_QUARANTINE_MS,
                       grace_ms:      RST_GRACE_MS};
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[rtl/sra_table.sv]
// Slot table: busy-bit memory and free-stamp memory, one read and one write
// port each, plus the post-reset clearing sweep. No package dependencies.
`timescale 1ns / 1ps

module sra_table #(
    parameter int SLOTS     = 1024,
    parameter int TIME_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [$clog2(SLOTS)-1:0] i_rd_addr,
    output logic                     o_rd_busy,
    output logic [TIME_BITS-1:0]     o_rd_stamp,
    input  logic                     i_wr_en,
    input  logic                     i_wr_stamp_en,
    input  logic [$clog2(SLOTS)-1:0] i_wr_addr,
    input  logic                     i_wr_busy,
    input  logic [TIME_BITS-1:0]     i_wr_stamp,
    output logic                     o_clearing
);
    localparam int IW = $clog2(SLOTS);
    localparam logic [IW-1:0] LAST_ADDR = IW'(SLOTS - 1);

    logic                 r_busy_mem [SLOTS];
    logic [TIME_BITS-1:0] r_stamp_mem [SLOTS];
    logic                 r_rd_busy;
    logic [TIME_BITS-1:0] r_rd_stamp;
    logic                 r_clearing;
    logic [IW-1:0]        r_clr_addr;

    logic                 w_we_busy;
    logic                 w_we_stamp;
    logic [IW-1:0]        w_addr;
    logic                 w_busy;
    logic [TIME_BITS-1:0] w_stamp;

    // sweep owns the write port until every entry is zeroed
    assign w_we_busy  = r_clearing || i_wr_en;
    assign w_we_stamp = r_clearing || (i_wr_en && i_wr_stamp_en);
    assign w_addr     = r_clearing ? r_clr_addr : i_wr_addr;
    assign w_busy     = r_clearing ? 1'b0 : i_wr_busy;
    assign w_stamp    = r_clearing ? '0 : i_wr_stamp;

    assign o_rd_busy  = r_rd_busy;
    assign o_rd_stamp = r_rd_stamp;
    assign o_clearing = r_clearing;

    always_ff @(posedge i_clk) begin
        if (w_we_busy) begin
            r_busy_mem[w_addr] <= w_busy;
        end
        if (w_we_stamp) begin
            r_stamp_mem[w_addr] <= w_stamp;
        end
        if (i_rd_en) begin
            r_rd_busy  <= r_busy_mem[i_rd_addr];
            r_rd_stamp <= r_stamp_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LAST_ADDR) begin
                r_clearing <= 1'b0;
            end
        end
    end

endmodule

[rtl/sra_engine.sv]
// Allocate/free sequencer: scans the slot table, decides the grant, writes
// back and holds the response register. Depends on sra_pkg, sra_if, macros.
`timescale 1ns / 1ps
`include "slot_allocator_reuse_delay_macros.svh"

module sra_engine #(
    parameter int SLOTS     = 1024,
    parameter int TIME_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  sra_pkg::t_cfg            i_cfg,
    input  logic                     i_clearing,
    sra_req_if.sink                  i_req,
    sra_rsp_if.source                o_rsp,
    output logic                     o_rd_en,
    output logic [$clog2(SLOTS)-1:0] o_rd_addr,
    input  logic                     i_rd_busy,
    input  logic [TIME_BITS-1:0]     i_rd_stamp,
    output logic                     o_wr_en,
    output logic                     o_wr_stamp_en,
    output logic [$clog2(SLOTS)-1:0] o_wr_addr,
    output logic                     o_wr_busy,
    output logic [TIME_BITS-1:0]     o_wr_stamp
);
    import sra_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int XW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int TW = TIME_BITS;
    localparam logic [XW-1:0] SLOTS_X = XW'(SLOTS);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [TW-1:0]       r_now;
    logic [XW-1:0]       r_end;
    logic [XW-1:0]       r_addr;
    logic                r_rd_vld;
    logic [IW-1:0]       r_rd_addr;
    logic                r_any_found;
    logic [IW-1:0]       r_any_slot;
    logic [XW-1:0]       r_hw;
    logic [IW-1:0]       r_res_slot;
    t_status             r_res_status;
    logic                r_res_wr;
    logic                r_res_busy;
    logic                r_res_stamp_wr;
    logic                r_out_vld;
    logic [SLOT_W-1:0]   r_out_slot;
    t_status             r_out_status;

    logic [XW-1:0]       w_fs;
    logic [XW-1:0]       w_sl;
    logic [XW-1:0]       w_span;
    logic [XW-1:0]       w_end;
    logic [XW-1:0]       w_lim;
    logic [XW-1:0]       w_idx_x;
    logic                w_protected;
    logic                w_accept;
    logic                w_is_free;
    logic                w_issue;
    logic [TW-1:0]       w_age;
    logic                w_strict;
    logic                w_hit;
    logic                w_scan_done;
    logic                w_grow;
    logic                w_out_free;

    // span in use is max(high water, first slot), capped at the table
    assign w_fs   = XW'(i_cfg.first_slot);
    assign w_sl   = XW'(i_cfg.slot_limit);
    assign w_span = (r_hw > w_fs) ? r_hw : w_fs;
    assign w_end  = (w_span > SLOTS_X) ? SLOTS_X : w_span;
    assign w_lim  = (w_sl > SLOTS_X) ? SLOTS_X : w_sl;
    assign w_grow = (r_end < w_lim) && (w_fs < SLOTS_X);

    assign w_idx_x     = XW'(i_req.slot_index);
    assign w_protected = (w_idx_x <= XW'(i_cfg.protect_limit)) || (w_idx_x >= SLOTS_X);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_is_free   = (t_op'(i_req.op) == OP_FREE);

    // one table read per cycle; data returns in the next cycle
    assign w_issue     = (r_state == S_SCAN) && (r_addr < r_end);
    assign w_age       = r_now - i_rd_stamp;
    assign w_strict    = !i_rd_busy && ((i_rd_stamp < TW'(i_cfg.grace_ms)) ||
                                        (w_age > TW'(i_cfg.quarantine_ms)));
    assign w_hit       = r_rd_vld && w_strict;
    assign w_scan_done = (r_state == S_SCAN) && !w_issue && !r_rd_vld;
    assign w_out_free  = !r_out_vld || o_rsp.ready;

    assign i_req.ready        = (r_state == S_IDLE) && !i_clearing;
    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.granted_slot = r_out_slot;
    assign o_rsp.status       = r_out_status;

    assign o_rd_en       = w_issue;
    assign o_rd_addr     = r_addr[IW-1:0];
    assign o_wr_en       = (r_state == S_FINISH) && w_out_free && r_res_wr;
    assign o_wr_stamp_en = r_res_stamp_wr;
    assign o_wr_addr     = r_res_slot;
    assign o_wr_busy     = r_res_busy;
    assign o_wr_stamp    = r_now;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_is_free ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_hit || w_scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_vld  <= 1'b0;
            r_hw      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_issue;
            if (w_scan_done && !r_rd_vld && w_grow) begin
                r_hw <= r_end + 1'b1;
            end
            if ((r_state == S_FINISH) && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && w_accept) begin
            r_now       <= TW'(i_req.now_ms);
            r_end       <= w_end;
            r_addr      <= w_fs;
            r_any_found <= 1'b0;
            if (w_is_free) begin
                r_res_slot     <= IW'(i_req.slot_index);
                r_res_status   <= w_protected ? ST_PROTECTED : ST_FREED;
                r_res_wr       <= !w_protected;
                r_res_busy     <= 1'b0;
                r_res_stamp_wr <= 1'b1;
            end
        end
        if (w_issue) begin
            r_addr    <= r_addr + 1'b1;
            r_rd_addr <= r_addr[IW-1:0];
        end
        // remember the lowest free slot as the fallback
        if (r_rd_vld && !i_rd_busy && !r_any_found) begin
            r_any_found <= 1'b1;
            r_any_slot  <= r_rd_addr;
        end
        if ((r_state == S_SCAN) && (w_hit || w_scan_done)) begin
            r_res_busy     <= 1'b1;
            r_res_stamp_wr <= 1'b0;
            r_res_wr       <= 1'b1;
            r_res_status   <= ST_GRANTED;
            if (w_hit) begin
                r_res_slot <= r_rd_addr;
            end else if (w_grow) begin
                r_res_slot <= r_end[IW-1:0];
            end else if (r_any_found) begin
                r_res_slot <= r_any_slot;
            end else begin
                r_res_wr     <= 1'b0;
                r_res_status <= ST_NONE;
            end
        end
        if ((r_state == S_FINISH) && w_out_free) begin
            r_out_status <= r_res_status;
            r_out_slot   <= (r_res_status == ST_GRANTED) ? SLOT_W'(r_res_slot) : '0;
        end
    end

    `SRA_ASSERT_ALWAYS(a_hw_bound, i_clk, i_rst_n, r_hw <= SLOTS_X, "high water beyond table")
    `SRA_ASSERT_NEXT(a_finish_loads, i_clk, i_rst_n, (r_state == S_FINISH) && w_out_free, r_out_vld && (r_state == S_IDLE), "finish did not load response")
    `SRA_ASSERT_IMPL(a_grant_in_span, i_clk, i_rst_n, (r_state == S_FINISH) && (r_res_status == ST_GRANTED), (XW'(r_res_slot) >= w_fs) && (XW'(r_res_slot) < SLOTS_X), "grant outside allocatable range")

endmodule

[rtl/slot_allocator_reuse_delay.sv]
// Free-slot allocator with reuse quarantine. Free item: accepted in S_IDLE, then S_FINISH loads the result.
// Allocate item: S_SCAN reads one slot a cycle from first_slot up and stops at the first reusable
// slot or at the end of that span, then S_FINISH loads the result.
// One item in flight; the next can be taken the cycle after its result is loaded, and S_FINISH
// waits while the previous response is still stalled in the output register.
// Reset: synchronous, active low; a sweep then zeroes the table, items wait for it.
`timescale 1ns / 1ps

module slot_allocator_reuse_delay #(
    parameter int SLOTS     = 1024,
    parameter int TIME_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    sra_req_if.sink                        i_req,
    sra_rsp_if.source                      o_rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sra_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sra_pkg::DATA_W-1:0]     pwdata,
    output logic [sra_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);
    import sra_pkg::*;

    localparam int IW = $clog2(SLOTS);

    t_cfg                 w_cfg;
    logic                 w_clearing;
    logic                 w_rd_en;
    logic [IW-1:0]        w_rd_addr;
    logic                 w_rd_busy;
    logic [TIME_BITS-1:0] w_rd_stamp;
    logic                 w_wr_en;
    logic                 w_wr_stamp_en;
    logic [IW-1:0]        w_wr_addr;
    logic                 w_wr_busy;
    logic [TIME_BITS-1:0] w_wr_stamp;

    // register file: values are to change only while no item is in flight; the block does not enforce it
    sra_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // busy bits and free stamps, one synchronous read port, one write port
    sra_table #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rd_en       (w_rd_en),
        .i_rd_addr     (w_rd_addr),
        .o_rd_busy     (w_rd_busy),
        .o_rd_stamp    (w_rd_stamp),
        .i_wr_en       (w_wr_en),
        .i_wr_stamp_en (w_wr_stamp_en),
        .i_wr_addr     (w_wr_addr),
        .i_wr_busy     (w_wr_busy),
        .i_wr_stamp    (w_wr_stamp),
        .o_clearing    (w_clearing)
    );

    // sequencer: scan, decide (reusable slot, grow, any free, none), write back
    sra_engine #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_clearing    (w_clearing),
        .i_req         (i_req),
        .o_rsp         (o_rsp),
        .o_rd_en       (w_rd_en),
        .o_rd_addr     (w_rd_addr),
        .i_rd_busy     (w_rd_busy),
        .i_rd_stamp    (w_rd_stamp),
        .o_wr_en       (w_wr_en),
        .o_wr_stamp_en (w_wr_stamp_en),
        .o_wr_addr     (w_wr_addr),
        .o_wr_busy     (w_wr_busy),
        .o_wr_stamp    (w_wr_stamp)
    );

endmodule

[verif/tb_slot_allocator_reuse_delay.sv]
// Testbench for slot_allocator_reuse_delay: a scoreboard mirrors the slot table and checks
// every response, while APB writes step the block through several register settings.
// Depends on sra_pkg, the sra_req_if / sra_rsp_if interfaces and the allocator RTL.
`timescale 1ns / 1ps

import sra_pkg::*;

typedef struct {
    logic [SLOT_W-1:0] slot;
    t_status           status;
} t_slot_outcome;

class slot_scoreboard;
    localparam int unsigned TABLE_SLOTS = 1024;

    bit                  busy[TABLE_SLOTS];
    logic [NOW_W-1:0]    freed_at[TABLE_SLOTS];
    int unsigned         high_water;
    int unsigned         first_slot;
    int unsigned         protect_limit;
    int unsigned         slot_limit;
    int unsigned         quarantine_ms;
    int unsigned         grace_ms;
    t_slot_outcome       outstanding[$];
    int                  errors;
    int                  tally[4];   // predicted outcomes, by status code

    function new();
        foreach (busy[i]) begin
            busy[i]     = 1'b0;
            freed_at[i] = '0;
        end
        high_water    = 0;
        first_slot    = RST_FIRST_SLOT;
        protect_limit = RST_PROTECT_LIMIT;
        slot_limit    = RST_SLOT_LIMIT;
        quarantine_ms = RST_QUARANTINE_MS;
        grace_ms      = RST_GRACE_MS;
        errors        = 0;
        foreach (tally[i]) tally[i] = 0;
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 40) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // mirror a register write; returns what the register holds afterwards
    function logic [DATA_W-1:0] set_reg(t_reg_idx r, logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] kept;
        kept = '0;
        case (r)
            REG_FIRST_SLOT: begin
                kept = DATA_W'(v[SLOT_W-1:0]);
                first_slot = kept;
            end
            REG_PROTECT_LIMIT: begin
                kept = DATA_W'(v[SLOT_W-1:0]);
                protect_limit = kept;
            end
            REG_SLOT_LIMIT: begin
                kept = DATA_W'(v[LIMIT_W-1:0]);
                slot_limit = kept;
            end
            REG_QUARANTINE_MS: begin
                kept = DATA_W'(v[MS_W-1:0]);
                quarantine_ms = kept;
            end
            REG_GRACE_MS: begin
                kept = DATA_W'(v[MS_W-1:0]);
                grace_ms = kept;
            end
            default: kept = '0;
        endcase
        return kept;
    endfunction

    // one past the last scanned slot: high water, never below first_slot, capped at the table
    function int unsigned scan_end();
        int unsigned e;
        e = (high_water > first_slot) ? high_water : first_slot;
        return (e > TABLE_SLOTS) ? TABLE_SLOTS : e;
    endfunction

    // lowest free slot below stop; strict also asks for grace or an expired quarantine
    function int find_reusable(int unsigned stop, logic [NOW_W-1:0] now, bit strict);
        logic [NOW_W-1:0] age;
        for (int unsigned i = first_slot; i < stop; i++) begin
            age = now - freed_at[i];
            if (!busy[i] && (!strict || freed_at[i] < grace_ms || age > quarantine_ms))
                return int'(i);
        end
        return -1;
    endfunction

    function t_slot_outcome predict_outcome(t_op op, logic [SLOT_W-1:0] idx,
                                            logic [NOW_W-1:0] now);
        t_slot_outcome res;
        int unsigned   stop;
        int unsigned   cap;
        int            got;
        res.slot   = '0;
        res.status = ST_NONE;
        if (op == OP_ALLOC) begin
            stop = scan_end();
            cap  = (slot_limit > TABLE_SLOTS) ? TABLE_SLOTS : slot_limit;
            got  = find_reusable(stop, now, 1'b1);
            if (got < 0 && stop < cap && first_slot < TABLE_SLOTS) begin
                got        = int'(stop);
                high_water = stop + 1;
            end
            if (got < 0) got = find_reusable(stop, now, 1'b0);
            if (got >= 0) begin
                busy[got]  = 1'b1;
                res.slot   = SLOT_W'(got);
                res.status = ST_GRANTED;
            end
        end else if (idx <= protect_limit) begin
            res.status = ST_PROTECTED;
        end else begin
            busy[idx]     = 1'b0;
            freed_at[idx] = now;
            res.status    = ST_FREED;
        end
        return res;
    endfunction

    function void note_item(t_op op, logic [SLOT_W-1:0] idx, logic [NOW_W-1:0] now);
        t_slot_outcome res;
        res = predict_outcome(op, idx, now);
        tally[int'(res.status)]++;
        outstanding.push_back(res);
    endfunction

    task check_response(logic [SLOT_W-1:0] slot, logic [STATUS_W-1:0] st);
        t_slot_outcome want;
        if (outstanding.size() == 0) begin
            report($sformatf("response with nothing outstanding: slot %0d status %0d",
                             slot, st));
            return;
        end
        want = outstanding.pop_front();
        if (st !== want.status)
            report($sformatf("status %0d, expected %s", st, want.status.name()));
        if (slot !== want.slot)
            report($sformatf("granted_slot %0d, expected %0d", slot, want.slot));
    endtask

    // a slot currently held, for well-formed free items; fallback when none is found quickly
    function logic [SLOT_W-1:0] held_slot(logic [SLOT_W-1:0] fallback);
        int unsigned stop;
        int unsigned s;
        stop = scan_end();
        if (stop > first_slot) begin
            for (int k = 0; k < 16; k++) begin
                s = $urandom_range(stop - 1, first_slot);
                if (busy[s]) return SLOT_W'(s);
            end
        end
        return fallback;
    endfunction
endclass

module tb_slot_allocator_reuse_delay;

    localparam int unsigned SLOT_COUNT  = 1024;
    // worst case: ~1150 items, each a full-table scan plus long stalls on both sides,
    // plus the clearing sweep after reset; several times over
    localparam int unsigned CYCLE_LIMIT = 4_000_000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sra_req_if req();
    sra_rsp_if rsp();

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    slot_allocator_reuse_delay #(
        .SLOTS     (SLOT_COUNT),
        .TIME_BITS (NOW_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    slot_scoreboard   sb = new();
    int               cycles = 0;
    bit               tx_steady = 1'b0;  // no gaps between items for this phase
    logic [NOW_W-1:0] wall_ms;           // running millisecond clock for the stimulus
    int               settings = 1;      // register settings visited, reset values included

    always #10 i_clk = ~i_clk;

    // Mostly back-to-back, sometimes a short gap, now and then a long one.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // ---------------------------------------------------------------------------------
    // Response side: random back-pressure, with runs of steady ready in between.
    // ---------------------------------------------------------------------------------
    initial begin : response_sink
        int stall;
        int stretch;
        bit steady;
        stall   = 0;
        stretch = 0;
        steady  = 1'b0;
        rsp.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stretch == 0) begin
                stretch = $urandom_range(50, 300);
                steady  = ($urandom_range(0, 3) == 0);
            end
            stretch--;
            if (stall > 0) begin
                stall--;
                rsp.ready <= 1'b0;
            end else begin
                rsp.ready <= 1'b1;
                if (!steady && $urandom_range(0, 3) == 0) stall = pick_gap();
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Response checking and the run limit.
    // ---------------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && rsp.valid && rsp.ready)
            sb.check_response(rsp.granted_slot, rsp.status);
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.outstanding.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------
    // Request side. valid stays high across back-to-back items; it is only lowered
    // when a gap follows, so it never gets two assignments in one step.
    // ---------------------------------------------------------------------------------
    task automatic send_item(t_op op, logic [SLOT_W-1:0] idx, logic [NOW_W-1:0] now);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.valid      <= 1'b1;
        req.op         <= op;
        req.slot_index <= idx;
        req.now_ms     <= now;
        do @(posedge i_clk); while (!req.ready);
        sb.note_item(op, idx, now);
    endtask

    // drop valid and wait until every predicted response is back
    task automatic drain();
        req.valid <= 1'b0;
        while (sb.outstanding.size() != 0) @(posedge i_clk);
    endtask

    // Time mostly moves forward in small steps (around the quarantine); sometimes it
    // jumps anywhere, runs backwards, or drops back into the grace window.
    task automatic random_item();
        int                p;
        t_op               op;
        logic [SLOT_W-1:0] idx;
        p = $urandom_range(0, 99);
        if (p < 3)      wall_ms = $urandom();
        else if (p < 6) wall_ms = wall_ms - $urandom_range(1, 800);
        else if (p < 8) wall_ms = $urandom_range(0, 3000);
        else            wall_ms = wall_ms + $urandom_range(0, 400);
        idx = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
        p   = $urandom_range(0, 99);
        op  = (p < 55) ? OP_ALLOC : OP_FREE;
        // most frees release a slot actually held; the rest hit arbitrary slots
        if (op == OP_FREE && p < 92) idx = sb.held_slot(idx);
        send_item(op, idx, wall_ms);
    endtask

    // ---------------------------------------------------------------------------------
    // APB. psel stays high across back-to-back transfers and is lowered by the caller.
    // ---------------------------------------------------------------------------------
    task automatic apb_access(bit wr, t_reg_idx r, logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= CFG_ADDR_W'(4 * r);
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
    endtask

    // write a register, mirror it, and read it back
    task automatic cfg_write(t_reg_idx r, logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] kept;
        logic [DATA_W-1:0] back;
        kept = sb.set_reg(r, v);
        apb_access(1'b1, r, v, back);
        apb_access(1'b0, r, '0, back);
        if (back !== kept)
            sb.report($sformatf("%s reads back %0d, expected %0d", r.name(), back, kept));
    endtask

    // One phase: program all registers while idle, then a random item stream.
    task automatic run_phase(int unsigned fs, int unsigned pl, int unsigned lim,
                             int unsigned qms, int unsigned gms, int n);
        cfg_write(REG_FIRST_SLOT, fs);
        cfg_write(REG_PROTECT_LIMIT, pl);
        cfg_write(REG_SLOT_LIMIT, lim);
        cfg_write(REG_QUARANTINE_MS, qms);
        cfg_write(REG_GRACE_MS, gms);
        psel    <= 1'b0;
        penable <= 1'b0;
        settings++;
        tx_steady = ($urandom_range(0, 3) == 0);
        repeat (n) random_item();
        drain();
    endtask

    initial begin
        req.valid      <= 1'b0;
        req.op         <= OP_ALLOC;
        req.slot_index <= '0;
        req.now_ms     <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        wall_ms         = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items at the reset settings (first slot 2, protect 1, quarantine 500,
        // grace 2000). The block holds off until its post-reset clear has finished.
        send_item(OP_FREE, 10'd0, 32'd0);           // protected, bottom slot
        send_item(OP_FREE, 10'd1, 32'd0);           // protected, on the limit
        send_item(OP_FREE, 10'd2, 32'd0);           // free of a slot never held
        send_item(OP_FREE, 10'd1023, 32'd0);        // top slot
        send_item(OP_ALLOC, 10'd1023, 32'd0);       // empty scan, table grows to slot 2
        send_item(OP_ALLOC, 10'd0, 32'd10);
        send_item(OP_ALLOC, 10'd0, 32'd20);
        send_item(OP_FREE, 10'd3, 32'd100);         // freed inside grace window
        send_item(OP_ALLOC, 10'd0, 32'd150);        // reused at once
        send_item(OP_FREE, 10'd3, 32'd5000);
        send_item(OP_ALLOC, 10'd0, 32'd5200);       // still quarantined: grows instead
        send_item(OP_ALLOC, 10'd0, 32'd5501);       // one past quarantine: reused
        send_item(OP_FREE, 10'd4, 32'd6000);
        send_item(OP_ALLOC, 10'd0, 32'd6500);       // exactly at quarantine: not yet
        send_item(OP_FREE, 10'd6, 32'd10000);
        send_item(OP_ALLOC, 10'd0, 32'd9000);       // lower slot expired normally
        send_item(OP_ALLOC, 10'd0, 32'd9001);       // time ran backwards: counts expired
        send_item(OP_FREE, 10'd5, 32'hFFFF_FFF0);
        send_item(OP_ALLOC, 10'd0, 32'h0000_0100);  // age across the wrap is short
        send_item(OP_ALLOC, 10'd0, 32'hFFFF_FFFF);
        send_item(OP_FREE, 10'd7, 32'hFFFF_FFFF);
        send_item(OP_ALLOC, 10'h2AA, 32'hAAAA_5555);
        drain();

        // random at reset settings, then a walk through the register space
        wall_ms = 32'd9000;
        repeat (100) random_item();
        drain();
        run_phase(1, 0, 24, 0, 0, 200);             // first slot 1, no quarantine
        run_phase(8, 12, 64, 65535, 65535, 200);    // widest quarantine and grace
        run_phase(3, 1023, 1, 300, 100, 100);       // nothing freeable, no growth
        run_phase(2, 2, 2047, 1000, 0, 200);        // limit beyond the table
        run_phase(1000, 500, 1024, 50, 2000, 150);  // high first slot, table fills up
        run_phase(1023, 1022, 1024, 0, 65535, 50);  // single allocatable slot
        run_phase(2, 1, 1024, 500, 2000, 130);      // back to reset values, long scans

        repeat (16) @(posedge i_clk);

        $display("%0d items over %0d register settings in %0d cycles",
                 sb.tally[ST_GRANTED] + sb.tally[ST_NONE] + sb.tally[ST_FREED]
                 + sb.tally[ST_PROTECTED], settings, cycles);
        $display("grants %0d, none free %0d, frees %0d, protected %0d, mismatches %0d",
                 sb.tally[ST_GRANTED], sb.tally[ST_NONE], sb.tally[ST_FREED],
                 sb.tally[ST_PROTECTED], sb.errors);
        if (sb.errors == 0 && sb.outstanding.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
